// ----- rtl/core/afcd_pkg.sv -----
// shared types, constants and color helpers for the animation frame chunk decoder
// no dependencies; imported by the parser and the top level
package afcd_pkg;

  // header word that closes a frame
  localparam logic [31:0] END_MARK = 32'h7FFF_7FFF;

  // 5-bit channel to 8-bit channel, c * 255 / 31 rounded down
  localparam logic [7:0] SCALE5_LUT [32] = '{
    8'd0,   8'd8,   8'd16,  8'd24,  8'd32,  8'd41,  8'd49,  8'd57,
    8'd65,  8'd74,  8'd82,  8'd90,  8'd98,  8'd106, 8'd115, 8'd123,
    8'd131, 8'd139, 8'd148, 8'd156, 8'd164, 8'd172, 8'd180, 8'd189,
    8'd197, 8'd205, 8'd213, 8'd222, 8'd230, 8'd238, 8'd246, 8'd255
  };

  // parse event seen on the current stream word, plus frame area
  typedef struct packed {
    logic        pixel;
    logic        eof;
    logic [31:0] addr;
    logic [31:0] area;
  } afcd_evt_t;

  // argb1555 to rgba8888, red in the low byte, alpha forced opaque
  function automatic logic [31:0] expand_color(input logic [15:0] c);
    expand_color = {8'hFF, SCALE5_LUT[c[4:0]], SCALE5_LUT[c[9:5]], SCALE5_LUT[c[14:10]]};
  endfunction

endpackage

// ----- rtl/core/afcd_palette.sv -----
// palette storage: one write port, one read port with registered data
// no package dependencies
module afcd_palette #(
  parameter int DEPTH = 256,
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [IDX_W-1:0] wr_idx,
  input  logic [15:0]      wr_data,
  input  logic             rd_en,
  input  logic [IDX_W-1:0] rd_idx,
  output logic [15:0]      rd_data_r
);

  logic [15:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_data;
    end
  end

  // read port, data held until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_idx];
    end
  end

endmodule

// ----- rtl/core/afcd_parser.sv -----
// stream parser: descriptor, chunk headers, pixel address sequencing
// depends on afcd_pkg for the event struct and end marker
module afcd_parser (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               byte_en,
  input  logic [7:0]         stream_byte,
  output afcd_pkg::afcd_evt_t evt
);
  import afcd_pkg::*;

  typedef enum logic [1:0] {
    PH_DESC = 2'd0,
    PH_HEAD = 2'd1,
    PH_PIX  = 2'd2
  } phase_t;

  phase_t       phase_r;
  logic [2:0]   pos_r;
  logic [23:0]  asm_r;
  logic [15:0]  cx_r, cy_r, w_r, h_r;
  logic [31:0]  waddr_r;
  logic [11:0]  left_r;
  logic [31:0]  base_r;
  logic [31:0]  area_r;

  logic [31:0]        hdr;
  logic [9:0]         hdr_x, hdr_y;
  logic [11:0]        hdr_cnt;
  logic signed [26:0] yw;
  logic [31:0]        chunk_addr;
  logic signed [31:0] xb;
  logic signed [18:0] yb;
  logic signed [34:0] yb_w;
  logic [31:0]        base_nxt;
  logic signed [31:0] area_nxt;
  logic [11:0]        left_dec;

  // header word with offset sign bits inverted
  assign hdr     = {stream_byte, asm_r};
  assign hdr_x   = {~hdr[31], hdr[30:22]};
  assign hdr_y   = {~hdr[21], hdr[20:12]};
  assign hdr_cnt = hdr[11:0];

  // chunk start address
  assign yw         = $signed({1'b0, hdr_y}) * $signed(w_r);
  assign chunk_addr = base_r + {{5{yw[26]}}, yw} + {22'b0, hdr_x};

  // frame base and area, refreshed every cycle from the descriptor
  assign xb       = $signed({{16{cx_r[15]}}, cx_r}) - 32'sd512;
  assign yb       = $signed({{3{cy_r[15]}}, cy_r}) + $signed({{3{h_r[15]}}, h_r}) - 19'sd512;
  assign yb_w     = yb * $signed(w_r);
  assign base_nxt = xb + yb_w[31:0];
  assign area_nxt = $signed(w_r) * $signed(h_r);

  assign left_dec = left_r - 12'd1;

  // events for the word in flight
  always_comb begin
    evt       = '0;
    evt.addr  = waddr_r;
    evt.area  = area_r;
    evt.pixel = byte_en && (phase_r == PH_PIX);
    evt.eof   = byte_en && (phase_r == PH_HEAD) && (pos_r[1:0] == 2'd3) && (hdr == END_MARK);
  end

  // parse state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_DESC;
      pos_r   <= '0;
      asm_r   <= '0;
      cx_r    <= '0;
      cy_r    <= '0;
      w_r     <= '0;
      h_r     <= '0;
      waddr_r <= '0;
      left_r  <= '0;
      base_r  <= '0;
      area_r  <= '0;
    end else begin
      base_r <= base_nxt;
      area_r <= area_nxt;
      if (byte_en) begin
        unique case (phase_r)
          PH_PIX: begin
            waddr_r <= waddr_r + 32'd1;
            left_r  <= left_dec;
            if (left_dec == 12'd0) begin
              phase_r <= PH_HEAD;
            end
          end
          PH_HEAD: begin
            if (pos_r[1:0] != 2'd3) begin
              asm_r[8*pos_r[1:0] +: 8] <= stream_byte;
              pos_r <= {1'b0, pos_r[1:0] + 2'd1};
            end else begin
              asm_r <= '0;
              pos_r <= '0;
              if (hdr == END_MARK) begin
                phase_r <= PH_DESC;
              end else begin
                waddr_r <= chunk_addr;
                left_r  <= hdr_cnt;
                phase_r <= (hdr_cnt != 12'd0) ? PH_PIX : PH_HEAD;
              end
            end
          end
          default: begin
            // descriptor: four little-endian halfwords
            unique case (pos_r[2:1])
              2'd0:    cx_r[8*pos_r[0] +: 8] <= stream_byte;
              2'd1:    cy_r[8*pos_r[0] +: 8] <= stream_byte;
              2'd2:    w_r[8*pos_r[0] +: 8]  <= stream_byte;
              default: h_r[8*pos_r[0] +: 8]  <= stream_byte;
            endcase
            if (pos_r != 3'd7) begin
              pos_r   <= pos_r + 3'd1;
              phase_r <= PH_DESC;
            end else begin
              pos_r   <= '0;
              asm_r   <= '0;
              phase_r <= PH_HEAD;
            end
          end
        endcase
      end
    end
  end

endmodule

// ----- rtl/core/anim_frame_chunk_decoder.sv -----
// animation frame chunk decoder: palette load, frame stream parse, pixel output
// path: an accepted word is captured in the stage 1 registers alongside the palette read, then in the result registers
// throughput: one word per cycle while the output is not stalled by out_ready
// reset: synchronous active-low rst_n clears parse state and both pipeline valids;
// palette contents are not cleared and must be written before they are read
module anim_frame_chunk_decoder #(
  parameter int PALETTE_ENTRIES = 256
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_action,
  input  logic [7:0]         in_palette_addr,
  input  logic [15:0]        in_palette_color,
  input  logic [7:0]         in_stream_byte,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_result_kind,
  output logic signed [31:0] out_pixel_address,
  output logic               out_in_frame,
  output logic [31:0]        out_pixel_color
);
  import afcd_pkg::*;

  localparam int IDX_W = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;

  logic       accept;
  logic       out_adv;
  afcd_evt_t  evt;
  logic       wr_ok, rd_ok;
  logic [15:0] pal_data;

  // stage 1 registers
  logic        s1_valid_r;
  logic        s1_eof_r;
  logic [31:0] s1_addr_r;
  logic [31:0] s1_area_r;
  logic        s1_idx_ok_r;

  // result registers
  logic        out_valid_r;
  logic        out_kind_r;
  logic [31:0] out_addr_r;
  logic        out_in_frame_r;
  logic [31:0] out_color_r;

  logic        in_frame_nxt;
  logic [31:0] color_nxt;

  // handshake
  assign out_adv  = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || out_adv;
  assign accept   = in_valid && in_ready;

  // palette index range checks
  assign wr_ok = {1'b0, in_palette_addr} < 9'(PALETTE_ENTRIES);
  assign rd_ok = {1'b0, in_stream_byte} < 9'(PALETTE_ENTRIES);

  afcd_parser u_parser (
    .clk         (clk),
    .rst_n       (rst_n),
    .byte_en     (accept && in_action),
    .stream_byte (in_stream_byte),
    .evt         (evt)
  );

  afcd_palette #(
    .DEPTH (PALETTE_ENTRIES)
  ) u_palette (
    .clk       (clk),
    .wr_en     (accept && !in_action && wr_ok),
    .wr_idx    (in_palette_addr[IDX_W-1:0]),
    .wr_data   (in_palette_color),
    .rd_en     (evt.pixel),
    .rd_idx    (in_stream_byte[IDX_W-1:0]),
    .rd_data_r (pal_data)
  );

  // stage 1: capture event alongside the palette read
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (accept) begin
      s1_valid_r <= evt.pixel || evt.eof;
    end else if (out_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_eof_r    <= evt.eof;
      s1_addr_r   <= evt.addr;
      s1_area_r   <= evt.area;
      s1_idx_ok_r <= rd_ok;
    end
  end

  // frame bounds and color expansion
  assign in_frame_nxt = !s1_eof_r && ($signed(s1_area_r) > 32'sd0) && !s1_addr_r[31]
                        && (s1_addr_r < s1_area_r);
  assign color_nxt    = s1_eof_r ? 32'd0
                      : expand_color(s1_idx_ok_r ? pal_data : 16'd0);

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_adv) begin
      out_kind_r     <= s1_eof_r;
      out_addr_r     <= s1_eof_r ? 32'd0 : s1_addr_r;
      out_in_frame_r <= in_frame_nxt;
      out_color_r    <= color_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_result_kind   = out_kind_r;
  assign out_pixel_address = $signed(out_addr_r);
  assign out_in_frame      = out_in_frame_r;
  assign out_pixel_color   = out_color_r;

endmodule

// ----- bench/tb.sv -----
// testbench for anim_frame_chunk_decoder: palette loads and frame streams checked
// word by word against a decoder model kept in the bench, under random stalls
// depends on afcd_pkg and the anim_frame_chunk_decoder rtl
module tb;
  import afcd_pkg::*;

  localparam logic        ACT_PALETTE     = 1'b0;
  localparam logic        ACT_STREAM      = 1'b1;
  localparam logic        KIND_PIXEL      = 1'b0;
  localparam logic        KIND_EOF        = 1'b1;
  localparam logic [31:0] OFFSET_FLIP     = 32'h8020_0000;
  localparam logic [31:0] ORIGIN_BIAS     = 32'h0000_0200;
  localparam int          ITEMS_PER_PHASE = 340;
  localparam int          LONG_HOLD       = 300;

  typedef enum logic [1:0] {PARSE_DESC, PARSE_HEAD, PARSE_PIX} parse_phase_t;

  typedef struct {
    logic        kind;
    logic [31:0] addr;
    logic        in_area;
    logic [31:0] color;
  } decoded_word_t;

  // decoder model: palette, parse position, frame geometry and pending output words
  class chunk_decode_model;
    logic [15:0]   palette [256];
    bit            loaded [256];
    logic [7:0]    loaded_list [$];
    parse_phase_t  phase;
    int unsigned   byte_pos;
    logic [31:0]   hdr_word;
    logic [15:0]   cx, cy, fw, fh;
    logic [31:0]   base_addr;
    logic [31:0]   wr_addr;
    logic [11:0]   left;
    decoded_word_t due [$];
    int            errors;
    int            pixels_seen;
    int            eofs_seen;

    function new();
      phase       = PARSE_DESC;
      byte_pos    = 0;
      hdr_word    = '0;
      cx          = '0;
      cy          = '0;
      fw          = '0;
      fh          = '0;
      base_addr   = '0;
      wr_addr     = '0;
      left        = '0;
      errors      = 0;
      pixels_seen = 0;
      eofs_seen   = 0;
    endfunction

    function logic [31:0] sext(logic [15:0] v);
      return {{16{v[15]}}, v};
    endfunction

    // 5-bit channel stretched to 8 bits, rounded down
    function logic [7:0] widen5(logic [4:0] c);
      logic [31:0] wide;
      wide = 32'(c) * 255 / 31;
      return wide[7:0];
    endfunction

    function logic [31:0] rgba_of(logic [15:0] c);
      return {8'hFF, widen5(c[4:0]), widen5(c[9:5]), widen5(c[14:10])};
    endfunction

    // inside the frame only when the area is positive and the address below it
    function logic area_hit(logic [31:0] a);
      logic signed [31:0] area;
      area = $signed(sext(fw)) * $signed(sext(fh));
      return (area > 0) && !a[31] && (a < 32'(area));
    endfunction

    // advance the model by one accepted input word
    function void take_word(logic act, logic [7:0] pa, logic [15:0] pc, logic [7:0] b);
      decoded_word_t r;
      logic [31:0]   h;
      if (act == ACT_PALETTE) begin
        palette[pa] = pc;
        if (!loaded[pa]) begin
          loaded[pa] = 1'b1;
          loaded_list.push_back(pa);
        end
        return;
      end
      case (phase)
        PARSE_PIX: begin
          r.kind    = KIND_PIXEL;
          r.addr    = wr_addr;
          r.in_area = area_hit(wr_addr);
          r.color   = rgba_of(palette[b]);
          due.push_back(r);
          wr_addr = wr_addr + 32'd1;
          left    = left - 12'd1;
          if (left == 12'd0) phase = PARSE_HEAD;
        end
        PARSE_HEAD: begin
          hdr_word[8*byte_pos +: 8] = b;
          if (byte_pos != 3) begin
            byte_pos++;
          end else begin
            h        = hdr_word;
            hdr_word = '0;
            byte_pos = 0;
            if (h == END_MARK) begin
              r.kind    = KIND_EOF;
              r.addr    = '0;
              r.in_area = 1'b0;
              r.color   = '0;
              due.push_back(r);
              phase = PARSE_DESC;
            end else begin
              // offsets carry an inverted top bit
              h       = h ^ OFFSET_FLIP;
              wr_addr = base_addr + 32'(h[21:12]) * sext(fw) + 32'(h[31:22]);
              left    = h[11:0];
              phase   = (left != 12'd0) ? PARSE_PIX : PARSE_HEAD;
            end
          end
        end
        default: begin
          case (byte_pos)
            0: cx[7:0]  = b;
            1: cx[15:8] = b;
            2: cy[7:0]  = b;
            3: cy[15:8] = b;
            4: fw[7:0]  = b;
            5: fw[15:8] = b;
            6: fh[7:0]  = b;
            default: fh[15:8] = b;
          endcase
          if (byte_pos != 7) begin
            byte_pos++;
          end else begin
            byte_pos  = 0;
            hdr_word  = '0;
            base_addr = (sext(cx) - ORIGIN_BIAS)
                      + (sext(cy) + sext(fh) - ORIGIN_BIAS) * sext(fw);
            phase     = PARSE_HEAD;
          end
        end
      endcase
    endfunction

    // compare one output word with the oldest pending one
    function void match_result(logic kind, logic [31:0] addr, logic in_area,
                               logic [31:0] color);
      decoded_word_t e;
      if (due.size() == 0) begin
        $display("%0t: output word with nothing pending, kind %b addr %h color %h",
                 $time, kind, addr, color);
        errors++;
        return;
      end
      e = due.pop_front();
      if (kind !== e.kind) begin
        $display("%0t: result_kind expected %b actual %b", $time, e.kind, kind);
        errors++;
      end
      if (addr !== e.addr) begin
        $display("%0t: pixel_address expected %h actual %h", $time, e.addr, addr);
        errors++;
      end
      if (in_area !== e.in_area) begin
        $display("%0t: in_frame expected %b actual %b", $time, e.in_area, in_area);
        errors++;
      end
      if (color !== e.color) begin
        $display("%0t: pixel_color expected %h actual %h", $time, e.color, color);
        errors++;
      end
      if (e.kind == KIND_EOF) eofs_seen++;
      else pixels_seen++;
    endfunction
  endclass

  logic               clk              = 1'b0;
  logic               rst_n            = 1'b0;
  logic               in_valid         = 1'b0;
  logic               in_ready;
  logic               in_action        = 1'b0;
  logic [7:0]         in_palette_addr  = '0;
  logic [15:0]        in_palette_color = '0;
  logic [7:0]         in_stream_byte   = '0;
  logic               out_valid;
  logic               out_ready        = 1'b0;
  logic               out_result_kind;
  logic signed [31:0] out_pixel_address;
  logic               out_in_frame;
  logic [31:0]        out_pixel_color;

  chunk_decode_model dec_model;
  int                send_idle_pct = 0;
  int                recv_idle_pct = 0;
  bit                hold_req      = 1'b0;
  int                items_sent    = 0;
  logic [63:0]       frame_desc    = '0;
  logic [31:0]       chunk_hdr     = '0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  anim_frame_chunk_decoder i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_action         (in_action),
    .in_palette_addr   (in_palette_addr),
    .in_palette_color  (in_palette_color),
    .in_stream_byte    (in_stream_byte),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_result_kind   (out_result_kind),
    .out_pixel_address (out_pixel_address),
    .out_in_frame      (out_in_frame),
    .out_pixel_color   (out_pixel_color)
  );

  // limit on the whole run
  initial begin
    #400000;
    $display("tb: failure");
    $finish;
  end

  // output side: random ready, or a long hold-off when requested
  initial begin
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // output monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      dec_model.match_result(out_result_kind, out_pixel_address, out_in_frame,
                             out_pixel_color);
  end

  // one input word: optional idle gap, then hold valid until accepted
  task automatic put_word(logic act, logic [7:0] pa, logic [15:0] pc, logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_action        <= act;
    in_palette_addr  <= pa;
    in_palette_color <= pc;
    in_stream_byte   <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    dec_model.take_word(act, pa, pc, b);
    items_sent++;
  endtask

  task automatic stream_put(logic [7:0] b);
    put_word(ACT_STREAM, 8'($urandom), 16'($urandom), b);
  endtask

  task automatic palette_put(logic [7:0] a, logic [15:0] c);
    put_word(ACT_PALETTE, a, c, 8'($urandom));
  endtask

  task automatic stream_put_word(logic [31:0] w);
    for (int k = 0; k < 4; k++) stream_put(w[8*k +: 8]);
  endtask

  // descriptor: mostly small frames near the origin, sometimes arbitrary bytes
  function automatic logic [63:0] plan_descriptor();
    logic [15:0] x, y, w, h;
    if ($urandom_range(99) < 20) return {$urandom, $urandom};
    x = 16'($urandom_range(16'h27F, 16'h180));
    y = 16'($urandom_range(16'h27F, 16'h180));
    w = 16'($urandom_range(24, 1));
    h = 16'($urandom_range(24, 1));
    return {h, w, y, x};
  endfunction

  // chunk header aimed around the frame, or the end marker
  function automatic logic [31:0] plan_header();
    int         col, row, cnt, w, h;
    logic [9:0] x, y;
    if ($urandom_range(99) < 18) return END_MARK;
    case ($urandom_range(19))
      0:       cnt = $urandom_range(300, 100);
      1, 2:    cnt = 0;
      default: cnt = $urandom_range(9, 1);
    endcase
    w = int'($signed(dec_model.fw));
    h = int'($signed(dec_model.fh));
    if (w < 1 || w > 64 || h < 1 || h > 64 || $urandom_range(99) < 25) begin
      x = 10'($urandom);
      y = 10'($urandom);
    end else begin
      col = int'($urandom_range(w + 5)) - 3;
      row = int'($urandom_range(h + 3)) - 2;
      x   = 10'(col + 512 - int'($signed(dec_model.cx)));
      y   = 10'(row + 512 - int'($signed(dec_model.cy)) - h);
    end
    return {x, y, 12'(cnt)} ^ OFFSET_FLIP;
  endfunction

  // index bytes only ever name loaded palette entries
  function automatic logic [7:0] pick_index();
    return dec_model.loaded_list[$urandom_range(dec_model.loaded_list.size() - 1)];
  endfunction

  // next random word, following where the parser stands
  task automatic next_random_item();
    logic [7:0] b;
    if ($urandom_range(99) < 8) begin
      palette_put(8'($urandom), 16'($urandom));
      return;
    end
    case (dec_model.phase)
      PARSE_PIX: b = pick_index();
      PARSE_HEAD: begin
        if (dec_model.byte_pos == 0) chunk_hdr = plan_header();
        b = chunk_hdr[8*dec_model.byte_pos +: 8];
        // corrupted header byte now and then, count kept below 512
        if ($urandom_range(99) < 4) begin
          b = 8'($urandom);
          if (dec_model.byte_pos == 1) b[3:0] = 4'($urandom_range(1));
        end
      end
      default: begin
        if (dec_model.byte_pos == 0) frame_desc = plan_descriptor();
        b = frame_desc[8*dec_model.byte_pos +: 8];
      end
    endcase
    stream_put(b);
  endtask

  // field extremes, empty chunk, palette write between pixels, end marker
  task automatic run_directed();
    palette_put(8'h00, 16'h0000);
    palette_put(8'hFF, 16'hFFFF);
    // centre x -32768, centre y 32767, width 32767, height -32768: negative area
    stream_put_word(32'h7FFF_8000);
    stream_put_word(32'h8000_7FFF);
    stream_put_word({10'h000, 10'h000, 12'd0} ^ OFFSET_FLIP);
    stream_put_word({10'h3FF, 10'h3FF, 12'd3} ^ OFFSET_FLIP);
    stream_put(8'h00);
    palette_put(8'h00, 16'h7C1F);
    stream_put(8'h00);
    stream_put(8'hFF);
    stream_put_word(END_MARK);
  endtask

  initial begin
    dec_model = new();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    send_idle_pct = 31;
    recv_idle_pct = 67;
    run_directed();

    // three idle profiles, output drained between them
    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          send_idle_pct = 31;
          recv_idle_pct = 67;
        end
        1: begin
          send_idle_pct = 67;
          recv_idle_pct = 31;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (ph == 0 && n == 120) hold_req = 1'b1;
        next_random_item();
      end
      in_valid <= 1'b0;
      @(posedge clk);
      while (dec_model.due.size() != 0) @(posedge clk);
    end

    // pipeline is two deep; the wait that follows catches stray words
    repeat (8) @(posedge clk);
    $display("run: %0d input words, %0d pixels and %0d frame ends compared",
             items_sent, dec_model.pixels_seen, dec_model.eofs_seen);
    $display("run: palette writes mid-frame, extreme descriptors, empty chunks, long stalls");
    if (dec_model.errors == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule
